/* sv/gaps_pkg.sv */
// ----------------------------------------------------------------------------
// gaps_pkg
// Types, constants and helpers shared by the grid A* path search block.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam int GridSide  = 32;
  localparam int CoordW    = 5;
  localparam int CellW     = 2 * CoordW;
  localparam int NumCells  = GridSide * GridSide;
  localparam int CostW     = 16;
  localparam int LenW      = CellW + 1;
  localparam int HeurW     = 10;
  localparam int SumSqW    = 11;
  localparam int RadW      = 18;
  localparam int RootW     = 9;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;
  localparam int ModeW     = 2;

  localparam logic [CostW-1:0] StepStraight = CostW'(10);
  localparam logic [CostW-1:0] StepDiag     = CostW'(14);

  localparam logic [ModeW-1:0] HeurManhattan = 2'd0;
  localparam logic [ModeW-1:0] HeurOctile    = 2'd1;
  localparam logic [ModeW-1:0] HeurEuclid    = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MARK_FREE   = 2'd0,
    MARK_OPEN   = 2'd1,
    MARK_CLOSED = 2'd2,
    MARK_UNUSED = 2'd3
  } mark_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PREAD,
    S_DONE,
    S_SCLR,
    S_INIT,
    S_SCAN,
    S_SEL,
    S_NRD,
    S_NEV,
    S_SQS,
    S_SQW,
    S_NWR,
    S_NNX,
    S_PW,
    S_PR
  } state_e;

  typedef struct packed {
    mark_e              mark;
    logic [CostW-1:0]   g;
    logic [CostW-1:0]   f;
    logic [CellW-1:0]   parent;
  } node_t;

  typedef struct packed {
    logic               we;
    logic [CellW-1:0]   waddr;
    node_t              wdata;
    logic [CellW-1:0]   raddr;
  } node_req_t;

  typedef struct packed {
    logic signed [1:0] di;
    logic signed [1:0] dj;
    logic              diag;
  } nb_off_t;

  // Neighbor order: dx outer, dy inner, the center skipped.
  function automatic nb_off_t nb_offset(input logic [2:0] ni);
    nb_off_t o;
    o.diag = 1'b0;
    unique case (ni)
      3'd0: begin o.di = -2'sd1; o.dj = -2'sd1; o.diag = 1'b1; end
      3'd1: begin o.di = -2'sd1; o.dj =  2'sd0; end
      3'd2: begin o.di = -2'sd1; o.dj =  2'sd1; o.diag = 1'b1; end
      3'd3: begin o.di =  2'sd0; o.dj = -2'sd1; end
      3'd4: begin o.di =  2'sd0; o.dj =  2'sd1; end
      3'd5: begin o.di =  2'sd1; o.dj = -2'sd1; o.diag = 1'b1; end
      3'd6: begin o.di =  2'sd1; o.dj =  2'sd0; end
      default: begin o.di = 2'sd1; o.dj = 2'sd1; o.diag = 1'b1; end
    endcase
    return o;
  endfunction

endpackage

/* sv/gaps_node_mem.sv */
// ----------------------------------------------------------------------------
// gaps_node_mem
// Per-cell search record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gaps_node_mem (
  input  logic             clk_i,
  input  gaps_pkg::node_req_t req_i,
  output gaps_pkg::node_t  rdata_o
);
  import gaps_pkg::*;

  node_t mem [NumCells];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/gaps_sqrt.sv */
// ----------------------------------------------------------------------------
// gaps_sqrt
// Iterative integer square root of 100 * sum, one result bit per cycle.
// ----------------------------------------------------------------------------
module gaps_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gaps_pkg::SumSqW-1:0] sum_i,
  output logic                        done_o,
  output logic [gaps_pkg::RootW-1:0]  root_o
);
  import gaps_pkg::*;

  logic             run_q;
  logic [RadW-1:0]  rad_q;
  logic [RootW-1:0] root_q;
  logic [RootW-1:0] bit_q;
  logic [RootW-1:0] cand;
  logic [RadW-1:0]  cand_sq;

  assign cand    = root_q | bit_q;
  assign cand_sq = RadW'(cand) * RadW'(cand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (run_q && (bit_q == '0)) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RadW'(sum_i) * RadW'(100);
      root_q <= '0;
      bit_q  <= {1'b1, {(RootW-1){1'b0}}};
    end else if (run_q && (bit_q != '0)) begin
      if (cand_sq <= rad_q) begin
        root_q <= cand;
      end
      bit_q <= bit_q >> 1;
    end
  end

  assign done_o = run_q && (bit_q == '0);
  assign root_o = root_q;

endmodule

/* sv/grid_astar_path_search_top.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search with eight neighbors on a 32 x 32 grid held in on-chip memories.
// ----------------------------------------------------------------------------
//  channel   signals                         role
//  in        in_valid_i / in_ready_o         map write, search, path read or nop
//  out       out_valid_o / out_ready_i       status and requested path cell
//  cfg       psel_i penable_i pwrite_i ...   heuristic_mode at address 0
//
// After reset the blocked map is cleared; no input is taken then.
// A search clears the node memory, then each expansion scans all 1024 node
// records through the single read port and visits 8 neighbors; the path walk
// then follows the parent links back from the goal to the start.
// A result waits in the output register; the next transaction is taken meanwhile.
// ----------------------------------------------------------------------------
module grid_astar_path_search_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [gaps_pkg::CoordW-1:0]  cell_x_i,
  input  logic [gaps_pkg::CoordW-1:0]  cell_y_i,
  input  logic                         cell_blocked_i,
  input  logic [gaps_pkg::CoordW-1:0]  start_x_i,
  input  logic [gaps_pkg::CoordW-1:0]  start_y_i,
  input  logic [gaps_pkg::CoordW-1:0]  goal_x_i,
  input  logic [gaps_pkg::CoordW-1:0]  goal_y_i,
  input  logic [gaps_pkg::CellW-1:0]   path_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [gaps_pkg::LenW-1:0]    path_length_o,
  output logic [gaps_pkg::CoordW-1:0]  step_x_o,
  output logic [gaps_pkg::CoordW-1:0]  step_y_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [gaps_pkg::AddrW-1:0]   paddr_i,
  input  logic [gaps_pkg::DataW-1:0]   pwdata_i,
  output logic [gaps_pkg::DataW-1:0]   prdata_o,
  output logic                         pready_o
);
  import gaps_pkg::*;

  state_e state_q, state_d;

  logic [ModeW-1:0]  mode_q;
  logic [CellW-1:0]  clr_q;
  logic [LenW-1:0]   sc_q;
  logic              rd_vld_q;
  logic              have_q;
  logic [CellW-1:0]  best_q;
  logic [CostW-1:0]  bestf_q;
  logic [CostW-1:0]  bestg_q;
  logic [CellW-1:0]  bestcf_q;
  logic [2:0]        ni_q;
  logic [CellW-1:0]  nb_q;
  logic              nb_diag_q;
  logic [CostW-1:0]  gnew_q;
  logic [HeurW-1:0]  h_q;
  logic [SumSqW-1:0] d2_q;
  logic [CellW-1:0]  start_q;
  logic [CellW-1:0]  goal_q;
  logic [CellW-1:0]  cur_q;
  logic [LenW-1:0]   n_q;
  logic              found_q;
  logic [LenW-1:0]   len_q;
  logic [CellW-1:0]  idx_q;
  logic [CoordW-1:0] rx_q, ry_q;
  logic              out_valid_q;
  logic              found_out_q;
  logic [LenW-1:0]   len_out_q;
  logic [CoordW-1:0] sx_out_q, sy_out_q;

  logic              in_acc;
  logic              cfg_wr;
  logic              out_free;
  node_req_t         node_req;
  node_t             node_rd;
  logic              map_mem [NumCells];
  logic              map_rd_q;
  logic              map_we;
  logic [CellW-1:0]  map_waddr;
  logic              map_wdata;
  logic [CellW-1:0]  path_mem [NumCells];
  logic [CellW-1:0]  path_rd_q;

  nb_off_t           off;
  logic [CoordW+1:0] nx7, ny7;
  logic              nb_in;
  logic [CellW-1:0]  nb_c;
  logic [CostW-1:0]  gnew_c;
  logic              upd_c;
  logic [CoordW-1:0] dx, dy, lo;
  logic [HeurW-1:0]  man_h, oct_h;
  logic              sq_start, sq_done;
  logic [RootW-1:0]  sq_root;
  logic              scan_better;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cfg_wr     = psel_i && penable_i && pwrite_i;
  assign pready_o   = 1'b1;
  assign prdata_o   = (paddr_i[2] == 1'b0) ? DataW'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= HeurManhattan;
    end else if (cfg_wr && (paddr_i[2] == 1'b0)) begin
      mode_q <= pwdata_i[ModeW-1:0];
    end
  end

  // Neighbor address and cost update decision.
  assign off    = nb_offset(ni_q);
  assign nx7    = {2'b00, best_q[CellW-1:CoordW]} + {{CoordW{off.di[1]}}, off.di};
  assign ny7    = {2'b00, best_q[CoordW-1:0]} + {{CoordW{off.dj[1]}}, off.dj};
  assign nb_in  = (nx7[CoordW+1:CoordW] == 2'b00) && (ny7[CoordW+1:CoordW] == 2'b00);
  assign nb_c   = {nx7[CoordW-1:0], ny7[CoordW-1:0]};
  assign gnew_c = bestg_q + (nb_diag_q ? StepDiag : StepStraight);
  assign upd_c  = (node_rd.mark != MARK_CLOSED) && !map_rd_q &&
                  !((node_rd.mark == MARK_OPEN) && (node_rd.g <= gnew_c));

  assign dx = (nb_q[CellW-1:CoordW] > goal_q[CellW-1:CoordW]) ?
              nb_q[CellW-1:CoordW] - goal_q[CellW-1:CoordW] :
              goal_q[CellW-1:CoordW] - nb_q[CellW-1:CoordW];
  assign dy = (nb_q[CoordW-1:0] > goal_q[CoordW-1:0]) ?
              nb_q[CoordW-1:0] - goal_q[CoordW-1:0] :
              goal_q[CoordW-1:0] - nb_q[CoordW-1:0];
  assign lo    = (dx < dy) ? dx : dy;
  assign man_h = (HeurW'(dx) + HeurW'(dy)) * HeurW'(10);
  assign oct_h = man_h - HeurW'(lo) * HeurW'(6);

  assign scan_better = (node_rd.mark == MARK_OPEN) && (!have_q || (node_rd.f < bestf_q));
  assign sq_start    = (state_q == S_SQS);

  gaps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .sum_i   (d2_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  gaps_node_mem u_node_mem (
    .clk_i   (clk_i),
    .req_i   (node_req),
    .rdata_o (node_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_q == CellW'(NumCells - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(kind_i))
            KIND_SEARCH: state_d = S_SCLR;
            KIND_READ:   state_d = S_PREAD;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_PREAD: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      S_SCLR:  if (clr_q == CellW'(NumCells - 1)) state_d = S_INIT;
      S_INIT:  state_d = S_SCAN;
      S_SCAN:  if (sc_q[LenW-1] && !rd_vld_q) state_d = S_SEL;
      S_SEL:   state_d = have_q ? S_NRD : S_DONE;
      S_NRD:   state_d = nb_in ? S_NEV : S_NNX;
      S_NEV: begin
        if (!upd_c) state_d = S_NNX;
        else if (mode_q == HeurEuclid) state_d = S_SQS;
        else state_d = S_NWR;
      end
      S_SQS:   state_d = S_SQW;
      S_SQW:   if (sq_done) state_d = S_NWR;
      S_NWR:   state_d = S_NNX;
      S_NNX: begin
        if (ni_q != 3'd7) state_d = S_NRD;
        else if (best_q == goal_q) state_d = S_PW;
        else state_d = S_SCAN;
      end
      S_PW:    state_d = S_PR;
      S_PR: begin
        if ((node_rd.parent == start_q) || (n_q == LenW'(NumCells))) state_d = S_DONE;
        else state_d = S_PW;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    node_req       = '0;
    node_req.raddr = sc_q[CellW-1:0];
    map_we         = 1'b0;
    map_waddr      = clr_q;
    map_wdata      = 1'b0;
    unique case (state_q)
      S_CLR: map_we = 1'b1;
      S_IDLE: begin
        map_we    = in_acc && (kind_e'(kind_i) == KIND_WRITE);
        map_waddr = {cell_x_i, cell_y_i};
        map_wdata = cell_blocked_i;
      end
      S_SCLR: begin
        node_req.we    = 1'b1;
        node_req.waddr = clr_q;
      end
      S_INIT: begin
        node_req.we           = 1'b1;
        node_req.waddr        = start_q;
        node_req.wdata.mark   = MARK_OPEN;
        node_req.wdata.parent = start_q;
      end
      S_SEL: begin
        node_req.we    = have_q;
        node_req.waddr = best_q;
        node_req.wdata = '{mark: MARK_CLOSED, g: bestg_q, f: bestf_q, parent: bestcf_q};
      end
      S_NRD: node_req.raddr = nb_c;
      S_NWR: begin
        node_req.we    = 1'b1;
        node_req.waddr = nb_q;
        node_req.wdata = '{mark: MARK_OPEN, g: gnew_q,
                           f: gnew_q + CostW'(h_q), parent: best_q};
      end
      S_PW: node_req.raddr = cur_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[nb_c];
    if (state_q == S_PW) begin
      path_mem[n_q[CellW-1:0]] <= cur_q;
    end
    path_rd_q <= path_mem[path_index_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      found_q     <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_SCAN) && !sc_q[LenW-1];
      if ((state_q == S_CLR) || (state_q == S_SCLR)) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc && (kind_e'(kind_i) == KIND_SEARCH)) begin
        found_q <= 1'b0;
        len_q   <= '0;
        clr_q   <= '0;
      end
      if ((state_q == S_PR) && (state_d == S_DONE)) begin
        found_q <= 1'b1;
        len_q   <= n_q;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search datapath.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      start_q <= {start_x_i, start_y_i};
      goal_q  <= {goal_x_i, goal_y_i};
      idx_q   <= path_index_i;
      rx_q    <= '0;
      ry_q    <= '0;
    end
    if (state_q == S_PREAD) begin
      if (LenW'(idx_q) < len_q) begin
        rx_q <= path_rd_q[CellW-1:CoordW];
        ry_q <= path_rd_q[CoordW-1:0];
      end
    end
    if ((state_q == S_INIT) || (state_q == S_NNX)) begin
      sc_q   <= '0;
      have_q <= 1'b0;
    end
    if ((state_q == S_SCAN) && !sc_q[LenW-1]) begin
      sc_q <= sc_q + 1'b1;
    end
    if (rd_vld_q && scan_better) begin
      have_q   <= 1'b1;
      best_q   <= sc_q[CellW-1:0] - 1'b1;
      bestf_q  <= node_rd.f;
      bestg_q  <= node_rd.g;
      bestcf_q <= node_rd.parent;
    end
    if (state_q == S_SEL) begin
      ni_q <= '0;
    end
    if (state_q == S_NRD) begin
      nb_q      <= nb_c;
      nb_diag_q <= off.diag;
    end
    if (state_q == S_NEV) begin
      gnew_q <= gnew_c;
      h_q    <= (mode_q == HeurOctile) ? oct_h : man_h;
      d2_q   <= SumSqW'(dx) * SumSqW'(dx) + SumSqW'(dy) * SumSqW'(dy);
    end
    if ((state_q == S_SQW) && sq_done) begin
      h_q <= HeurW'(sq_root);
    end
    if (state_q == S_NNX) begin
      ni_q <= ni_q + 1'b1;
      cur_q <= goal_q;
      n_q   <= '0;
    end
    if (state_q == S_PW) begin
      n_q <= n_q + 1'b1;
    end
    if (state_q == S_PR) begin
      cur_q <= node_rd.parent;
    end
    if ((state_q == S_DONE) && out_free) begin
      found_out_q <= found_q;
      len_out_q   <= len_q;
      sx_out_q    <= rx_q;
      sy_out_q    <= ry_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_out_q;
  assign path_length_o = len_out_q;
  assign step_x_o      = sx_out_q;
  assign step_y_o      = sy_out_q;

  a_status_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (len_q == '0))
    else $error("path length set without a found path");

  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_SQW))
    else $error("square root finished outside its wait state");

  a_idle_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !node_req.we)
    else $error("node memory written while idle");

endmodule
